// ----- src/swac_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swac_pkg
// shared types and constants of the swept box velocity clamp
// ----------------------------------------------------------------------------
package swac_pkg;

    localparam int SPEED_BITS     = 24;
    localparam int DT_BITS        = 16;
    localparam int DIM_BITS       = 15;
    localparam int PAR_BITS       = 16;
    localparam int CULL_BITS      = 35;
    localparam int FRAC_BITS      = 24;
    localparam int DISP_BITS      = SPEED_BITS + DT_BITS + 1;
    localparam int CFG_INDEX_BITS = 2;

    localparam logic [CFG_INDEX_BITS-1:0] CFG_CAMERA_X = 2'd0;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_CAMERA_Y = 2'd1;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_PARALLAX = 2'd2;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_CULL     = 2'd3;

    localparam logic [PAR_BITS-1:0]  PARALLAX_RESET = 16'd256;
    localparam logic [CULL_BITS-1:0] CULL_RESET     = {CULL_BITS{1'b1}};

    localparam logic KIND_BEGIN    = 1'b0;
    localparam logic KIND_COLLIDER = 1'b1;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_AX,
        ST_AY,
        ST_SQX,
        ST_SQY,
        ST_CULL,
        ST_DX,
        ST_DY,
        ST_RESP,
        ST_FIN
    } state_t;

    typedef struct packed {
        logic                         grounded;
        logic signed [SPEED_BITS-1:0] new_speed_y;
        logic signed [SPEED_BITS-1:0] new_speed_x;
    } result_t;

endpackage

// ----- src/swept_aabb_velocity_clamp_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swept_aabb_velocity_clamp_top
// swept box collision response with velocity clamping, stream interface
// ----------------------------------------------------------------------------
// A query is a begin request (tuser 0) followed by collider requests
// (tuser 1); the request with tlast set produces one result holding the
// clamped speed and the grounded flag. All multiplications run through a
// single shared multiplier under a small sequencer, and s_tready is low
// while an item is in work. A begin request skips the multiplier and goes
// straight to the final hand-off. A collider runs six multiplications
// (camera x and y times parallax, the two distance squares, the two
// displacements) issued one at a time on that multiplier, plus a step for
// the centre differences, one for the overlap decision and the final
// hand-off; when it is culled by the centre distance test, it skips the
// displacements and the overlap decision. A result sits in the output
// register until taken; a further tlast request waits in its final state
// only while that register is still full.
// ----------------------------------------------------------------------------
module swept_aabb_velocity_clamp_top
    import swac_pkg::*;
#(
    parameter int COORD_BITS = 16
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    // input requests
    input  logic                      s_tvalid,
    output logic                      s_tready,
    // rect_x, rect_y, rect_w, rect_h, speed_x, speed_y, step_dt, zero fill
    input  logic [((2*COORD_BITS+94+7)/8)*8-1:0] s_tdata,
    // kind
    input  logic                      s_tuser,
    input  logic                      s_tlast,
    // results
    output logic                      m_tvalid,
    input  logic                      m_tready,
    // new_speed_x, new_speed_y, grounded, zero fill
    output logic [55:0]               m_tdata,
    // configuration writes
    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  logic [CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [CULL_BITS-1:0]      cfg_data
);

    // field offsets inside s_tdata
    localparam int RY_LSB = COORD_BITS;
    localparam int RW_LSB = 2 * COORD_BITS;
    localparam int RH_LSB = RW_LSB + DIM_BITS;
    localparam int SX_LSB = RH_LSB + DIM_BITS;
    localparam int SY_LSB = SX_LSB + SPEED_BITS;
    localparam int DT_LSB = SY_LSB + SPEED_BITS;
    localparam int RES_BITS = 2 * SPEED_BITS + 1;

    logic signed [COORD_BITS-1:0] camera_x;
    logic signed [COORD_BITS-1:0] camera_y;
    logic [PAR_BITS-1:0]          parallax;
    logic [CULL_BITS-1:0]         cull_threshold;

    logic                         res_valid;
    result_t                      res;
    logic                         out_free;

    logic                         m_valid_reg, m_valid_next;
    result_t                      m_data_reg, m_data_next;

    swac_cfg #(
        .COORD_BITS (COORD_BITS)
    ) u_cfg (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .camera_x       (camera_x),
        .camera_y       (camera_y),
        .parallax       (parallax),
        .cull_threshold (cull_threshold)
    );

    swac_core #(
        .COORD_BITS (COORD_BITS)
    ) u_core (
        .clk            (clk),
        .rst_n          (rst_n),
        .item_valid     (s_tvalid),
        .item_ready     (s_tready),
        .kind           (s_tuser),
        .rect_x         (s_tdata[COORD_BITS-1:0]),
        .rect_y         (s_tdata[RY_LSB +: COORD_BITS]),
        .rect_w         (s_tdata[RW_LSB +: DIM_BITS]),
        .rect_h         (s_tdata[RH_LSB +: DIM_BITS]),
        .speed_x        (s_tdata[SX_LSB +: SPEED_BITS]),
        .speed_y        (s_tdata[SY_LSB +: SPEED_BITS]),
        .step_dt        (s_tdata[DT_LSB +: DT_BITS]),
        .last           (s_tlast),
        .camera_x       (camera_x),
        .camera_y       (camera_y),
        .parallax       (parallax),
        .cull_threshold (cull_threshold),
        .out_free       (out_free),
        .res_valid      (res_valid),
        .res            (res)
    );

    // output register: free when empty or being taken this cycle
    assign out_free = !m_valid_reg || m_tready;

    always_comb
    begin
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        if (res_valid)
        begin
            m_valid_next = 1'b1;
            m_data_next  = res;
        end
        else if (m_tready)
        begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_valid_reg <= 1'b0;
        end
        else
        begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        m_data_reg <= m_data_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {{(56-RES_BITS){1'b0}}, m_data_reg};

endmodule

// ----- src/swac_cfg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swac_cfg
// configuration register file: camera offset, parallax and cull threshold
// ----------------------------------------------------------------------------
module swac_cfg
    import swac_pkg::*;
#(
    parameter int COORD_BITS = 16
)
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [CFG_INDEX_BITS-1:0]   cfg_index,
    input  logic [CULL_BITS-1:0]        cfg_data,
    output logic signed [COORD_BITS-1:0] camera_x,
    output logic signed [COORD_BITS-1:0] camera_y,
    output logic [PAR_BITS-1:0]         parallax,
    output logic [CULL_BITS-1:0]        cull_threshold
);

    logic signed [COORD_BITS-1:0] camera_x_reg;
    logic signed [COORD_BITS-1:0] camera_y_reg;
    logic [PAR_BITS-1:0]          parallax_reg;
    logic [CULL_BITS-1:0]         cull_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            camera_x_reg <= '0;
            camera_y_reg <= '0;
            parallax_reg <= PARALLAX_RESET;
            cull_reg     <= CULL_RESET;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                CFG_CAMERA_X: camera_x_reg <= cfg_data[COORD_BITS-1:0];
                CFG_CAMERA_Y: camera_y_reg <= cfg_data[COORD_BITS-1:0];
                CFG_PARALLAX: parallax_reg <= cfg_data[PAR_BITS-1:0];
                CFG_CULL:     cull_reg     <= cfg_data;
                default:      cull_reg     <= cull_reg;
            endcase
        end
    end

    assign camera_x       = camera_x_reg;
    assign camera_y       = camera_y_reg;
    assign parallax       = parallax_reg;
    assign cull_threshold = cull_reg;

endmodule

// ----- src/swac_mul.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swac_mul
// shared signed multiplier with registered product
// ----------------------------------------------------------------------------
module swac_mul
    import swac_pkg::*;
#(
    parameter int W = 26
)
(
    input  logic                  clk,
    input  logic                  en,
    input  logic signed [W-1:0]   a,
    input  logic signed [W-1:0]   b,
    output logic signed [2*W-1:0] p
);

    logic signed [2*W-1:0] p_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p_reg <= a * b;
        end
    end

    assign p = p_reg;

endmodule

// ----- src/swac_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swac_core
// sequencer and datapath: cull test and swept overlap on one shared multiplier
// ----------------------------------------------------------------------------
module swac_core
    import swac_pkg::*;
#(
    parameter int COORD_BITS = 16
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         item_valid,
    output logic                         item_ready,
    input  logic                         kind,
    input  logic signed [COORD_BITS-1:0] rect_x,
    input  logic signed [COORD_BITS-1:0] rect_y,
    input  logic [DIM_BITS-1:0]          rect_w,
    input  logic [DIM_BITS-1:0]          rect_h,
    input  logic signed [SPEED_BITS-1:0] speed_x,
    input  logic signed [SPEED_BITS-1:0] speed_y,
    input  logic [DT_BITS-1:0]           step_dt,
    input  logic                         last,
    input  logic signed [COORD_BITS-1:0] camera_x,
    input  logic signed [COORD_BITS-1:0] camera_y,
    input  logic [PAR_BITS-1:0]          parallax,
    input  logic [CULL_BITS-1:0]         cull_threshold,
    input  logic                         out_free,
    output logic                         res_valid,
    output result_t                      res
);

    // coordinate width covers collider shifted by camera times parallax
    localparam int KW = COORD_BITS + 10;
    localparam int MW = (KW > SPEED_BITS + 1) ? KW : SPEED_BITS + 1;
    localparam int PW = 2 * MW;
    localparam int DW = 2 * KW;
    localparam int CW = KW + FRAC_BITS;

    state_t state_reg, state_next;

    // query state
    logic signed [KW-1:0]         box_x_reg, box_x_next;
    logic signed [KW-1:0]         box_y_reg, box_y_next;
    logic signed [KW-1:0]         box_xe_reg, box_xe_next;
    logic signed [KW-1:0]         box_ye_reg, box_ye_next;
    logic signed [KW-1:0]         cbx_reg, cbx_next;
    logic signed [KW-1:0]         cby_reg, cby_next;
    logic signed [SPEED_BITS-1:0] spd_x_reg, spd_x_next;
    logic signed [SPEED_BITS-1:0] spd_y_reg, spd_y_next;
    logic [DT_BITS-1:0]           dt_reg, dt_next;
    logic                         ground_reg, ground_next;

    // per item work registers
    logic signed [COORD_BITS-1:0] rx_reg, rx_next;
    logic signed [COORD_BITS-1:0] ry_reg, ry_next;
    logic [DIM_BITS-1:0]          rw_reg, rw_next;
    logic [DIM_BITS-1:0]          rh_reg, rh_next;
    logic                         last_reg, last_next;
    logic signed [KW-1:0]         ax_reg, ax_next;
    logic signed [KW-1:0]         ay_reg, ay_next;
    logic signed [KW-1:0]         axe_reg, axe_next;
    logic signed [KW-1:0]         aye_reg, aye_next;
    logic signed [KW-1:0]         ddx_reg, ddx_next;
    logic signed [KW-1:0]         ddy_reg, ddy_next;
    logic [DW-1:0]                dist_reg, dist_next;
    logic signed [DISP_BITS-1:0]  dx_reg, dx_next;
    logic signed [DISP_BITS-1:0]  dy_reg, dy_next;
    logic                         hx1_reg, hx1_next;
    logic                         hx2_reg, hx2_next;
    logic                         hx6_reg, hx6_next;
    logic                         xov_reg, xov_next;
    logic                         yov_reg, yov_next;

    logic                         mul_en;
    logic signed [MW-1:0]         mul_a;
    logic signed [MW-1:0]         mul_b;
    logic signed [PW-1:0]         prod;

    logic signed [PW-1:0]         prod_adj;
    logic signed [KW-1:0]         cam_shift;
    logic [DW-1:0]                dist_sum;
    logic signed [CW-1:0]         dxe;
    logic signed [CW-1:0]         dye;
    logic signed [KW-1:0]         d1, d2, d6, d3, d4, d5;
    logic signed [CW-1:0]         lim1, lim2, lim6, lim3, lim4, lim5;
    logic                         hy3, hy4, hy5;
    logic                         accept;

    swac_mul #(
        .W (MW)
    ) u_mul (
        .clk (clk),
        .en  (mul_en),
        .a   (mul_a),
        .b   (mul_b),
        .p   (prod)
    );

    assign item_ready = (state_reg == ST_IDLE);
    assign accept     = item_valid && item_ready;

    // camera times parallax over 256, truncated toward zero
    assign prod_adj  = prod[PW-1] ? prod + PW'(255) : prod;
    assign cam_shift = KW'(prod_adj >>> 8);
    assign dist_sum  = dist_reg + DW'(prod);

    assign dxe = CW'(dx_reg);
    assign dye = CW'(dy_reg);

    // sweep bounds relative to the moving box, scaled to the displacement grid
    assign d1   = ax_reg - box_xe_reg;
    assign d2   = axe_reg - box_x_reg;
    assign d6   = ax_reg - box_x_reg;
    assign d3   = ay_reg - box_ye_reg;
    assign d4   = aye_reg - box_y_reg;
    assign d5   = ay_reg - box_y_reg;
    assign lim1 = {d1, {FRAC_BITS{1'b0}}};
    assign lim2 = {d2, {FRAC_BITS{1'b0}}};
    assign lim6 = {d6, {FRAC_BITS{1'b0}}};
    assign lim3 = {d3, {FRAC_BITS{1'b0}}};
    assign lim4 = {d4, {FRAC_BITS{1'b0}}};
    assign lim5 = {d5, {FRAC_BITS{1'b0}}};
    assign hy3  = dye > lim3;
    assign hy4  = dye < lim4;
    assign hy5  = dye > lim5;

    always_comb
    begin
        state_next  = state_reg;
        box_x_next  = box_x_reg;
        box_y_next  = box_y_reg;
        box_xe_next = box_xe_reg;
        box_ye_next = box_ye_reg;
        cbx_next    = cbx_reg;
        cby_next    = cby_reg;
        spd_x_next  = spd_x_reg;
        spd_y_next  = spd_y_reg;
        dt_next     = dt_reg;
        ground_next = ground_reg;
        rx_next     = rx_reg;
        ry_next     = ry_reg;
        rw_next     = rw_reg;
        rh_next     = rh_reg;
        last_next   = last_reg;
        ax_next     = ax_reg;
        ay_next     = ay_reg;
        axe_next    = axe_reg;
        aye_next    = aye_reg;
        ddx_next    = ddx_reg;
        ddy_next    = ddy_reg;
        dist_next   = dist_reg;
        dx_next     = dx_reg;
        dy_next     = dy_reg;
        hx1_next    = hx1_reg;
        hx2_next    = hx2_reg;
        hx6_next    = hx6_reg;
        xov_next    = xov_reg;
        yov_next    = yov_reg;
        mul_en      = 1'b0;
        mul_a       = '0;
        mul_b       = '0;
        res_valid   = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    rx_next   = rect_x;
                    ry_next   = rect_y;
                    rw_next   = rect_w;
                    rh_next   = rect_h;
                    last_next = last;
                    if (kind == KIND_BEGIN)
                    begin
                        box_x_next  = KW'(rect_x) - KW'(camera_x);
                        box_y_next  = KW'(rect_y) - KW'(camera_y);
                        box_xe_next = KW'(rect_x) - KW'(camera_x) + KW'(rect_w);
                        box_ye_next = KW'(rect_y) - KW'(camera_y) + KW'(rect_h);
                        cbx_next    = KW'(rect_x) - KW'(camera_x) + KW'(rect_w >> 1);
                        cby_next    = KW'(rect_y) - KW'(camera_y) + KW'(rect_h >> 1);
                        spd_x_next  = speed_x;
                        spd_y_next  = speed_y;
                        dt_next     = step_dt;
                        ground_next = 1'b0;
                        state_next  = ST_FIN;
                    end
                    else
                    begin
                        mul_en     = 1'b1;
                        mul_a      = MW'(camera_x);
                        mul_b      = MW'(parallax);
                        state_next = ST_AX;
                    end
                end
            end
            ST_AX:
            begin
                ax_next    = KW'(rx_reg) - cam_shift;
                mul_en     = 1'b1;
                mul_a      = MW'(camera_y);
                mul_b      = MW'(parallax);
                state_next = ST_AY;
            end
            ST_AY:
            begin
                ay_next    = KW'(ry_reg) - cam_shift;
                axe_next   = ax_reg + KW'(rw_reg);
                ddx_next   = ax_reg + KW'(rw_reg >> 1) - cbx_reg;
                state_next = ST_SQX;
            end
            ST_SQX:
            begin
                mul_en     = 1'b1;
                mul_a      = MW'(ddx_reg);
                mul_b      = MW'(ddx_reg);
                aye_next   = ay_reg + KW'(rh_reg);
                ddy_next   = ay_reg + KW'(rh_reg >> 1) - cby_reg;
                state_next = ST_SQY;
            end
            ST_SQY:
            begin
                dist_next  = DW'(prod);
                mul_en     = 1'b1;
                mul_a      = MW'(ddy_reg);
                mul_b      = MW'(ddy_reg);
                state_next = ST_CULL;
            end
            ST_CULL:
            begin
                // far colliders are skipped
                if (dist_sum > DW'(cull_threshold))
                begin
                    state_next = ST_FIN;
                end
                else
                begin
                    mul_en     = 1'b1;
                    mul_a      = MW'(spd_x_reg);
                    mul_b      = MW'(dt_reg);
                    state_next = ST_DX;
                end
            end
            ST_DX:
            begin
                dx_next    = DISP_BITS'(prod);
                mul_en     = 1'b1;
                mul_a      = MW'(spd_y_reg);
                mul_b      = MW'(dt_reg);
                state_next = ST_DY;
            end
            ST_DY:
            begin
                dy_next    = DISP_BITS'(prod);
                hx1_next   = dxe > lim1;
                hx2_next   = dxe < lim2;
                hx6_next   = dxe > lim6;
                xov_next   = (box_x_reg < axe_reg) && (box_xe_reg > ax_reg);
                yov_next   = (box_y_reg < aye_reg) && (box_ye_reg > ay_reg);
                state_next = ST_RESP;
            end
            ST_RESP:
            begin
                if (hx1_reg && hx2_reg && hy3 && hy4)
                begin
                    // both axis decisions use the speed from before this collider
                    if (xov_reg)
                    begin
                        if (hy4 && hy5 && dy_reg[DISP_BITS-1])
                        begin
                            spd_y_next = '0;
                        end
                        else if (hy3 && !dy_reg[DISP_BITS-1])
                        begin
                            spd_y_next  = '0;
                            ground_next = 1'b1;
                        end
                    end
                    if (yov_reg)
                    begin
                        if (hx2_reg && hx6_reg && dx_reg[DISP_BITS-1])
                        begin
                            spd_x_next = '0;
                        end
                        else if (hx1_reg && !dx_reg[DISP_BITS-1])
                        begin
                            spd_x_next = '0;
                        end
                    end
                end
                state_next = ST_FIN;
            end
            ST_FIN:
            begin
                if (!last_reg)
                begin
                    state_next = ST_IDLE;
                end
                else if (out_free)
                begin
                    res_valid  = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign res.new_speed_x = spd_x_reg;
    assign res.new_speed_y = spd_y_reg;
    assign res.grounded    = ground_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            box_x_reg  <= '0;
            box_y_reg  <= '0;
            box_xe_reg <= '0;
            box_ye_reg <= '0;
            cbx_reg    <= '0;
            cby_reg    <= '0;
            spd_x_reg  <= '0;
            spd_y_reg  <= '0;
            dt_reg     <= '0;
            ground_reg <= 1'b0;
            last_reg   <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            box_x_reg  <= box_x_next;
            box_y_reg  <= box_y_next;
            box_xe_reg <= box_xe_next;
            box_ye_reg <= box_ye_next;
            cbx_reg    <= cbx_next;
            cby_reg    <= cby_next;
            spd_x_reg  <= spd_x_next;
            spd_y_reg  <= spd_y_next;
            dt_reg     <= dt_next;
            ground_reg <= ground_next;
            last_reg   <= last_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rx_reg   <= rx_next;
        ry_reg   <= ry_next;
        rw_reg   <= rw_next;
        rh_reg   <= rh_next;
        ax_reg   <= ax_next;
        ay_reg   <= ay_next;
        axe_reg  <= axe_next;
        aye_reg  <= aye_next;
        ddx_reg  <= ddx_next;
        ddy_reg  <= ddy_next;
        dist_reg <= dist_next;
        dx_reg   <= dx_next;
        dy_reg   <= dy_next;
        hx1_reg  <= hx1_next;
        hx2_reg  <= hx2_next;
        hx6_reg  <= hx6_next;
        xov_reg  <= xov_next;
        yov_reg  <= yov_next;
    end

endmodule

// ----- dv/tb_swept_aabb_velocity_clamp_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_swept_aabb_velocity_clamp_top
// self-checking bench for the swept box velocity clamp
// ----------------------------------------------------------------------------
// Drives begin and collider requests on the input stream and configuration
// writes on their own channel. A scoreboard class keeps its own copy of the
// camera, parallax and cull settings and of the moving box, works out the
// clamped speed and grounded flag for every request with tlast set, and
// compares each result taken from the output stream against the oldest one
// it holds. A short directed part covers the field extremes and the basic
// hit cases; random phases with changing settings follow, mostly well-formed
// queries aimed around the moving box, plus broken queries and raw noise.
// ----------------------------------------------------------------------------
module tb_swept_aabb_velocity_clamp_top;

    import swac_pkg::*;

    localparam int COORD_BITS  = 16;
    localparam int TDATA_W     = ((2*COORD_BITS+94+7)/8)*8;
    localparam int RESULT_W    = 56;

    // request field offsets inside s_tdata, lowest first
    localparam int X_LO        = 0;
    localparam int Y_LO        = COORD_BITS;
    localparam int W_LO        = 2*COORD_BITS;
    localparam int H_LO        = W_LO + DIM_BITS;
    localparam int SX_LO       = H_LO + DIM_BITS;
    localparam int SY_LO       = SX_LO + SPEED_BITS;
    localparam int DT_LO       = SY_LO + SPEED_BITS;

    // cycles with no accepted transfer on any channel before giving up
    localparam int QUIET_LIMIT = 5000;
    // long receiver hold-off used to back the block up
    localparam int HOLD_CYCLES = 300;
    // a collider without tlast may still be in work when the queue drains
    localparam int SETTLE      = 20;
    localparam int ITEMS_PHASE = 183;

    typedef struct {
        logic                         kind;
        logic                         last;
        logic signed [COORD_BITS-1:0] rx;
        logic signed [COORD_BITS-1:0] ry;
        logic [DIM_BITS-1:0]          rw;
        logic [DIM_BITS-1:0]          rh;
        logic signed [SPEED_BITS-1:0] sx;
        logic signed [SPEED_BITS-1:0] sy;
        logic [DT_BITS-1:0]           dt;
    } swac_req_t;

    // ------------------------------------------------------------------------
    // scoreboard: predicts the clamped speed and holds the pending results
    // ------------------------------------------------------------------------
    class speed_clamp_scoreboard;
        logic signed [COORD_BITS-1:0] cam_x;
        logic signed [COORD_BITS-1:0] cam_y;
        logic [PAR_BITS-1:0]          par;
        logic [CULL_BITS-1:0]         cull;
        logic signed [COORD_BITS:0]   box_x;
        logic signed [COORD_BITS:0]   box_y;
        logic [DIM_BITS-1:0]          box_w;
        logic [DIM_BITS-1:0]          box_h;
        logic signed [SPEED_BITS-1:0] spd_x;
        logic signed [SPEED_BITS-1:0] spd_y;
        logic [DT_BITS-1:0]           step;
        logic                         grounded;
        result_t                      clamped_q[$];
        int                           errors;

        function new();
            cam_x    = '0;
            cam_y    = '0;
            par      = PARALLAX_RESET;
            cull     = CULL_RESET;
            box_x    = '0;
            box_y    = '0;
            box_w    = '0;
            box_h    = '0;
            spd_x    = '0;
            spd_y    = '0;
            step     = '0;
            grounded = 1'b0;
            errors   = 0;
        endfunction

        function int pending();
            return clamped_q.size();
        endfunction

        function void write_reg(logic [CFG_INDEX_BITS-1:0] idx, logic [CULL_BITS-1:0] data);
            case (idx)
                CFG_CAMERA_X: cam_x = data[COORD_BITS-1:0];
                CFG_CAMERA_Y: cam_y = data[COORD_BITS-1:0];
                CFG_PARALLAX: par   = data[PAR_BITS-1:0];
                CFG_CULL:     cull  = data;
                default:      ;
            endcase
        endfunction

        // camera times Q8.8 parallax, truncated toward zero
        function longint cam_shift(logic signed [COORD_BITS-1:0] cam);
            longint c;
            longint f;
            longint p;
            c = cam;
            f = par;
            p = c * f;
            return (p >= 0) ? p / 256 : -((-p) / 256);
        endfunction

        // swept overlap test, all coordinates scaled to Q.24
        function void sweep(longint ax, longint ay, longint aw, longint ah);
            longint one;
            longint st;
            longint dx;
            longint dy;
            longint bxi;
            longint byi;
            longint bw;
            longint bh;
            longint bx;
            longint by;
            longint bxe;
            longint bye;
            longint axs;
            longint ays;
            longint axe;
            longint aye;
            one = longint'(1) << FRAC_BITS;
            st  = step;
            dx  = spd_x;
            dx  = dx * st;
            dy  = spd_y;
            dy  = dy * st;
            bxi = box_x;
            byi = box_y;
            bw  = box_w;
            bh  = box_h;
            bx  = bxi * one;
            by  = byi * one;
            bxe = (bxi + bw) * one;
            bye = (byi + bh) * one;
            axs = ax * one;
            ays = ay * one;
            axe = (ax + aw) * one;
            aye = (ay + ah) * one;
            if (!(bxe + dx > axs && bx + dx < axe && bye + dy > ays && by + dy < aye))
                return;
            // horizontal spans overlap: vertical motion is blocked
            if (bxi < ax + aw && bxi + bw > ax)
            begin
                if (by + dy < aye && by + dy > ays && dy < 0)
                    spd_y = '0;
                else if (bye + dy > ays && dy >= 0)
                begin
                    spd_y    = '0;
                    grounded = 1'b1;
                end
            end
            // vertical spans overlap: horizontal motion is blocked
            if (byi < ay + ah && byi + bh > ay)
            begin
                if (bx + dx < axe && bx + dx > axs && dx < 0)
                    spd_x = '0;
                else if (bxe + dx > axs && dx >= 0)
                    spd_x = '0;
            end
        endfunction

        function void note_request(logic kind, logic last, logic [TDATA_W-1:0] d);
            longint  rx;
            longint  ry;
            longint  rw;
            longint  rh;
            longint  ax;
            longint  ay;
            longint  bxi;
            longint  byi;
            longint  bw;
            longint  bh;
            longint  ddx;
            longint  ddy;
            longint  sq_dist;
            result_t res;
            rx = $signed(d[X_LO +: COORD_BITS]);
            ry = $signed(d[Y_LO +: COORD_BITS]);
            rw = d[W_LO +: DIM_BITS];
            rh = d[H_LO +: DIM_BITS];
            if (kind == KIND_BEGIN)
            begin
                box_x    = rx - cam_x;
                box_y    = ry - cam_y;
                box_w    = d[W_LO +: DIM_BITS];
                box_h    = d[H_LO +: DIM_BITS];
                spd_x    = d[SX_LO +: SPEED_BITS];
                spd_y    = d[SY_LO +: SPEED_BITS];
                step     = d[DT_LO +: DT_BITS];
                grounded = 1'b0;
            end
            else
            begin
                ax      = rx - cam_shift(cam_x);
                ay      = ry - cam_shift(cam_y);
                bxi     = box_x;
                byi     = box_y;
                bw      = box_w;
                bh      = box_h;
                ddx     = (ax + rw / 2) - (bxi + bw / 2);
                ddy     = (ay + rh / 2) - (byi + bh / 2);
                sq_dist = ddx * ddx + ddy * ddy;
                if (sq_dist <= cull)
                    sweep(ax, ay, rw, rh);
            end
            if (last)
            begin
                res.new_speed_x = spd_x;
                res.new_speed_y = spd_y;
                res.grounded    = grounded;
                clamped_q.push_back(res);
            end
        endfunction

        function void check_result(logic [RESULT_W-1:0] d);
            result_t exp_res;
            logic signed [SPEED_BITS-1:0] got_x;
            logic signed [SPEED_BITS-1:0] got_y;
            logic got_g;
            got_x = d[0 +: SPEED_BITS];
            got_y = d[SPEED_BITS +: SPEED_BITS];
            got_g = d[2*SPEED_BITS];
            if (clamped_q.size() == 0)
            begin
                errors++;
                if (errors <= 10)
                    $display("unexpected result: x=%0d y=%0d g=%0d", got_x, got_y, got_g);
                return;
            end
            exp_res = clamped_q.pop_front();
            if (got_x !== exp_res.new_speed_x || got_y !== exp_res.new_speed_y
                || got_g !== exp_res.grounded)
            begin
                errors++;
                if (errors <= 10)
                    $display("result mismatch: expected x=%0d y=%0d g=%0d, got x=%0d y=%0d g=%0d",
                             exp_res.new_speed_x, exp_res.new_speed_y, exp_res.grounded,
                             got_x, got_y, got_g);
            end
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // block under test
    // ------------------------------------------------------------------------
    logic                      clk;
    logic                      rst_n;
    logic                      s_tvalid;
    logic                      s_tready;
    // rect_x, rect_y, rect_w, rect_h, speed_x, speed_y, step_dt, zero fill
    logic [TDATA_W-1:0]        s_tdata;
    // kind
    logic                      s_tuser;
    logic                      s_tlast;
    logic                      m_tvalid;
    logic                      m_tready;
    // new_speed_x, new_speed_y, grounded, zero fill
    logic [RESULT_W-1:0]       m_tdata;
    logic                      cfg_valid;
    logic                      cfg_ready;
    logic [CFG_INDEX_BITS-1:0] cfg_index;
    logic [CULL_BITS-1:0]      cfg_data;

    swept_aabb_velocity_clamp_top #(
        .COORD_BITS (COORD_BITS)
    ) i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    speed_clamp_scoreboard sb = new();

    // idle chances in percent, changed per phase
    int src_idle  = 18;
    int dst_idle  = 73;
    // set by the stimulus, picked up by the receiver process
    bit hold_req  = 1'b0;
    int hold_left = 0;
    int sent      = 0;
    int quiet     = 0;

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // ------------------------------------------------------------------------
    // monitors: sample pre-edge values of every accepted transfer
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (cfg_valid && cfg_ready)
                sb.write_reg(cfg_index, cfg_data);
            if (s_tvalid && s_tready)
                sb.note_request(s_tuser, s_tlast, s_tdata);
            if (m_tvalid && m_tready)
                sb.check_result(m_tdata);
        end
    end

    // ------------------------------------------------------------------------
    // receiver: random stalls, or a long hold-off when asked for
    // ------------------------------------------------------------------------
    initial
    begin
        m_tready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_req)
            begin
                hold_req  = 1'b0;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                m_tready <= 1'b0;
            end
            else
                m_tready <= ($urandom_range(99) >= dst_idle);
        end
    end

    // ------------------------------------------------------------------------
    // watchdog: ends the run when nothing moves for too long
    // ------------------------------------------------------------------------
    initial
    begin
        while (quiet < QUIET_LIMIT)
        begin
            @(posedge clk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("tb_swept_aabb_velocity_clamp_top failed");
        $finish;
    end

    // ------------------------------------------------------------------------
    // drivers
    // ------------------------------------------------------------------------

    // one input request; tvalid stays high afterwards unless a gap follows
    task automatic send_req(input swac_req_t r);
        while ($urandom_range(99) < src_idle)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= r.kind;
        s_tlast  <= r.last;
        s_tdata  <= TDATA_W'({r.dt, r.sy, r.sx, r.rh, r.rw, r.ry, r.rx});
        do @(posedge clk); while (!s_tready);
        sent++;
    endtask

    // one register write; cfg_valid is lowered by the caller after the batch
    task automatic write_cfg(input logic [CFG_INDEX_BITS-1:0] idx,
                             input logic [CULL_BITS-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge clk); while (!cfg_ready);
    endtask

    // a begin request and a few colliders placed around the moving box;
    // a broken query gets random tlast bits instead of one at the end
    task automatic send_query(input bit broken);
        swac_req_t r;
        int        n;
        int        bx;
        int        by;
        int        pos;
        r.kind = KIND_BEGIN;
        if ($urandom_range(7) == 0)
        begin
            r.rx = COORD_BITS'($urandom);
            r.ry = COORD_BITS'($urandom);
        end
        else
        begin
            r.rx = COORD_BITS'(int'($urandom_range(2000)) - 1000);
            r.ry = COORD_BITS'(int'($urandom_range(2000)) - 1000);
        end
        case ($urandom_range(9))
            0:       r.rw = '0;
            1:       r.rw = DIM_BITS'($urandom);
            default: r.rw = DIM_BITS'($urandom_range(1, 64));
        endcase
        case ($urandom_range(9))
            0:       r.rh = '0;
            1:       r.rh = DIM_BITS'($urandom);
            default: r.rh = DIM_BITS'($urandom_range(1, 64));
        endcase
        // speeds mostly within a few dozen pixels per step
        case ($urandom_range(9))
            0:       r.sx = '0;
            1:       r.sx = SPEED_BITS'($urandom);
            default: r.sx = SPEED_BITS'(int'($urandom_range(24576)) - 12288);
        endcase
        case ($urandom_range(9))
            0:       r.sy = '0;
            1:       r.sy = SPEED_BITS'($urandom);
            default: r.sy = SPEED_BITS'(int'($urandom_range(24576)) - 12288);
        endcase
        r.dt   = DT_BITS'($urandom);
        n      = $urandom_range(5);
        r.last = broken ? 1'($urandom_range(1)) : (n == 0);
        send_req(r);
        // box position on screen, as the block stores it
        bx = int'(r.rx) - int'(sb.cam_x);
        by = int'(r.ry) - int'(sb.cam_y);
        for (int k = 0; k < n; k++)
        begin
            r.kind = KIND_COLLIDER;
            pos    = bx + int'($urandom_range(200)) - 100 + int'(sb.cam_shift(sb.cam_x));
            r.rx   = COORD_BITS'(pos);
            pos    = by + int'($urandom_range(200)) - 100 + int'(sb.cam_shift(sb.cam_y));
            r.ry   = COORD_BITS'(pos);
            r.rw   = ($urandom_range(15) == 0) ? 15'd0 : 15'($urandom_range(1, 80));
            r.rh   = ($urandom_range(15) == 0) ? 15'd0 : 15'($urandom_range(1, 80));
            // ignored on colliders, kept moving for toggling
            r.sx   = SPEED_BITS'($urandom);
            r.sy   = SPEED_BITS'($urandom);
            r.dt   = DT_BITS'($urandom);
            r.last = broken ? 1'($urandom_range(1)) : (k == n - 1);
            send_req(r);
        end
    endtask

    // drain, write all registers, then a stretch of random traffic
    task automatic run_phase(input logic signed [COORD_BITS-1:0] cx,
                             input logic signed [COORD_BITS-1:0] cy,
                             input logic [PAR_BITS-1:0] par,
                             input logic [CULL_BITS-1:0] cull,
                             input int s_idle,
                             input int d_idle,
                             input bit pressure);
        swac_req_t r;
        int        target;
        int        pick;
        // sender pauses until the block has nothing left in work
        s_tvalid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
        write_cfg(CFG_CAMERA_X, CULL_BITS'(cx));
        write_cfg(CFG_CAMERA_Y, CULL_BITS'(cy));
        write_cfg(CFG_PARALLAX, CULL_BITS'(par));
        write_cfg(CFG_CULL, cull);
        cfg_valid <= 1'b0;
        src_idle  = s_idle;
        dst_idle  = d_idle;
        // receiver stops for a while, the sender keeps offering
        if (pressure)
            hold_req = 1'b1;
        target = sent + ITEMS_PHASE;
        while (sent < target)
        begin
            pick = $urandom_range(99);
            if (pick < 78)
                send_query(1'b0);
            else if (pick < 90)
                send_query(1'b1);
            else
            begin
                // raw noise request, every field fully random
                r.kind = 1'($urandom_range(1));
                r.last = 1'($urandom_range(1));
                r.rx   = COORD_BITS'($urandom);
                r.ry   = COORD_BITS'($urandom);
                r.rw   = DIM_BITS'($urandom);
                r.rh   = DIM_BITS'($urandom);
                r.sx   = SPEED_BITS'($urandom);
                r.sy   = SPEED_BITS'($urandom);
                r.dt   = DT_BITS'($urandom);
                send_req(r);
            end
        end
    endtask

    // ------------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------------
    initial
    begin
        rst_n     = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tuser   = 1'b0;
        s_tlast   = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed part, reset settings
        // collider before any begin, hits the zero box with zero speed
        send_req('{KIND_COLLIDER, 1, -5, -5, 10, 10, 0, 0, 0});
        // begin with tlast, field extremes
        send_req('{KIND_BEGIN, 1, 32767, -32768, 32767, 0, 8388607, -8388608, 65535});
        send_req('{KIND_BEGIN, 1, -32768, 32767, 0, 32767, -8388608, 8388607, 0});
        // falling onto a floor
        send_req('{KIND_BEGIN, 0, 0, 0, 10, 10, 0, 5120, 32768});
        send_req('{KIND_COLLIDER, 1, 0, 15, 20, 5, 0, 0, 0});
        // jumping into a ceiling
        send_req('{KIND_BEGIN, 0, 0, 0, 10, 10, 0, -5120, 32768});
        send_req('{KIND_COLLIDER, 1, 0, -15, 20, 10, 0, 0, 0});
        // moving left into a wall
        send_req('{KIND_BEGIN, 0, 0, 0, 10, 10, -5120, 0, 32768});
        send_req('{KIND_COLLIDER, 1, -15, 0, 10, 10, 0, 0, 0});
        // right wall missed while the box also moves down, then a floor, then a far miss
        send_req('{KIND_BEGIN, 0, 0, 0, 10, 10, 5120, 5120, 32768});
        send_req('{KIND_COLLIDER, 0, 15, 0, 10, 10, 0, 0, 0});
        send_req('{KIND_COLLIDER, 0, 0, 15, 20, 5, 0, 0, 0});
        send_req('{KIND_COLLIDER, 1, 1000, 1000, 5, 5, 0, 0, 0});
        // requests without tlast, then a collider at the top extremes
        send_req('{KIND_BEGIN, 0, 100, 100, 16, 16, 256, 0, 65535});
        send_req('{KIND_COLLIDER, 0, 115, 100, 8, 8, 0, 0, 0});
        send_req('{KIND_COLLIDER, 1, 32767, 32767, 32767, 32767, -1, -1, 65535});
        // collider at the bottom extremes with zero size
        send_req('{KIND_COLLIDER, 1, -32768, -32768, 0, 0, 0, 0, 0});

        // sender idle chance 18 percent, receiver 73 percent
        run_phase(0, 0, 256, CULL_RESET, 18, 73, 1'b0);
        run_phase(-32768, 32767, 65535, CULL_RESET, 18, 73, 1'b1);
        run_phase(100, -50, 128, 2000, 18, 73, 1'b0);
        // the other way round
        run_phase(COORD_BITS'($urandom), COORD_BITS'($urandom), 0, 0, 73, 18, 1'b0);
        run_phase(32767, -32768, 384, 400, 73, 18, 1'b0);
        run_phase(COORD_BITS'($urandom), COORD_BITS'($urandom), PAR_BITS'($urandom),
                  CULL_BITS'($urandom_range(30000)), 73, 18, 1'b0);
        // no idling on either side
        run_phase(0, 0, 256, CULL_RESET, 0, 0, 1'b1);
        run_phase(COORD_BITS'($urandom), COORD_BITS'($urandom), PAR_BITS'($urandom),
                  CULL_BITS'({$urandom, $urandom}), 0, 0, 1'b0);
        run_phase(-1, 1, 1, CULL_RESET - 1, 0, 0, 1'b0);

        s_tvalid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (30) @(posedge clk);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("tb_swept_aabb_velocity_clamp_top passed");
        else
            $display("tb_swept_aabb_velocity_clamp_top failed");
        $finish;
    end

endmodule

// ----- files.f -----
src/swac_pkg.sv
src/swac_cfg.sv
src/swac_mul.sv
src/swac_core.sv
src/swept_aabb_velocity_clamp_top.sv
dv/tb_swept_aabb_velocity_clamp_top.sv
